[rtl/core/wpbp_pkg.sv]
// ----------------------------------------------------------------------------
// Windowed peak boundary picker package
// Shared constants, the register index codes and the per-cell control group.
// ----------------------------------------------------------------------------
package wpbp_pkg;

    // Default build values for the top-level parameters.
    localparam int MAX_RADIUS_DEF = 31;
    localparam int PROB_BITS_DEF  = 16;

    // Radius register: fixed five-bit field, plus one bit for count compares.
    localparam int RADIUS_W   = 5;
    localparam int CNT_CMP_W  = RADIUS_W + 1;

    // Register reset values.
    localparam int THRESH_RESET = 32768;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_RADIUS    = 1'b1
    } t_cfg_idx;

    // Control handed from the sequencer to one window cell each cycle.
    typedef struct packed {
        logic shift;       // take the neighbour's frame (decision made)
        logic clear;       // sequence finished, forget every frame
        logic load;        // write the incoming frame here
        logic keep;        // inside the left reach, or the frame in hand not finished
        logic look_left;   // older neighbour inside the decision window
        logic look_right;  // newer neighbour inside the decision window
    } t_cell_ctl;

endpackage

[rtl/core/wpbp_cell.sv]
// ----------------------------------------------------------------------------
// Window cell
// Holds one frame of the sliding window, shifts it towards the older end on
// each decision and compares its key with the key of the frame under decision.
// ----------------------------------------------------------------------------
module wpbp_cell #(
    parameter int PROB_BITS = wpbp_pkg::PROB_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wpbp_pkg::t_cell_ctl    i_ctl,
    input  logic [PROB_BITS+1:0]   i_new,
    input  logic [PROB_BITS+1:0]   i_nb_ent,
    input  logic                   i_nb_pres,
    input  logic [PROB_BITS:0]     i_cand_key,
    output logic [PROB_BITS+1:0]   o_ent,
    output logic                   o_pres,
    output logic [PROB_BITS:0]     o_key,
    output logic                   o_beat
);

    // Frame layout: valid flag, barrier flag, probability.
    logic [PROB_BITS+1:0] r_ent;
    logic [PROB_BITS+1:0] n_ent;
    logic                 r_pres;
    logic                 n_pres;
    logic                 w_valid;
    logic                 w_barrier;

    assign w_valid   = r_ent[PROB_BITS+1];
    assign w_barrier = r_ent[PROB_BITS];

    // Padding and barrier frames rank above every probability.
    assign o_key = (!w_valid || w_barrier) ? {1'b1, {PROB_BITS{1'b0}}}
                                           : {1'b0, r_ent[PROB_BITS-1:0]};

    // An older frame wins ties, a newer one must be strictly greater.
    assign o_beat = r_pres && ((i_ctl.look_left  && (o_key >= i_cand_key)) ||
                               (i_ctl.look_right && (o_key >  i_cand_key)));

    assign o_ent  = r_ent;
    assign o_pres = r_pres;

    // Next contents: shift, then drop, then load the incoming frame.
    always_comb begin
        n_ent  = r_ent;
        n_pres = r_pres;
        if (i_ctl.shift) begin
            n_ent  = i_nb_ent;
            n_pres = i_nb_pres;
        end
        if (i_ctl.clear || !i_ctl.keep) begin
            n_pres = 1'b0;
        end
        if (i_ctl.load) begin
            n_ent  = i_new;
            n_pres = 1'b1;
        end
    end

    // Frame data needs no reset; the presence bit does.
    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_pres <= 1'b0;
        end else begin
            r_pres <= n_pres;
        end
    end

endmodule

[rtl/core/windowed_peak_boundary_picker_core.sv]
// ----------------------------------------------------------------------------
// Windowed peak boundary picker
// Sliding-window local-maximum peak picking over a row of window cells.
// ----------------------------------------------------------------------------
// The block takes one frame per input transfer and returns one boundary
// decision per frame, radius frames late; the final frame of a sequence
// flushes all pending decisions at once. Decisions leave one per cycle,
// while the output is not stalled, through a single output register, and
// a new frame is taken only once the frame in hand has released all its
// decisions. In a steady stream each frame releases one decision, and the block
// accepts a new frame in every cycle while the output is not stalled. The
// 2*MAX_RADIUS cells beside the centre cell compare against it in parallel,
// which sets the combinational decision path. Presence bits in the cells are
// cleared by reset at once, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module windowed_peak_boundary_picker_core #(
    parameter int MAX_RADIUS = wpbp_pkg::MAX_RADIUS_DEF,
    parameter int PROB_BITS  = wpbp_pkg::PROB_BITS_DEF,
    localparam int CFG_W     = (PROB_BITS > wpbp_pkg::RADIUS_W) ? PROB_BITS
                                                                 : wpbp_pkg::RADIUS_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [wpbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]                i_cfg_data,
    // Frame input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [PROB_BITS-1:0]            i_prob,
    input  logic                            i_barrier,
    input  logic                            i_valid_req,
    input  logic                            i_seq_last,
    // Decision output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_boundary,
    output logic                            o_seq_end,
    output logic                            o_run_end
);

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int CTR   = MAX_RADIUS;
    localparam int CW    = $clog2(MAX_RADIUS + 2);
    localparam int ENT_W = PROB_BITS + 2;
    localparam int CMPW  = wpbp_pkg::CNT_CMP_W;
    localparam int RW    = wpbp_pkg::RADIUS_W;

    // Configuration registers.
    logic [PROB_BITS-1:0] r_thresh;
    logic [RW-1:0]        r_radius;
    logic [RW-1:0]        w_radius_wr;

    // Sequencer state.
    logic                 r_busy;
    logic                 r_last;
    logic [CW-1:0]        r_pend;

    // Output register.
    logic                 r_out_valid;
    logic                 r_boundary;
    logic                 r_seq_end;
    logic                 r_run_end;

    // Sequencer signals.
    logic                 w_need;
    logic                 w_more;
    logic                 w_fire;
    logic                 w_item_done;
    logic                 w_ready;
    logic                 w_in_acc;
    logic [CW-1:0]        w_pend_m1;
    logic [CW-1:0]        w_pend_base;
    logic [CMPW-1:0]      w_radius_x;
    logic                 w_decision;

    // Cell row: one extra slot past the newest end reads as empty.
    logic [DEPTH:0][ENT_W-1:0]     w_ent;
    logic [DEPTH:0]                w_pres;
    logic [DEPTH-1:0][PROB_BITS:0] w_key;
    logic [DEPTH-1:0]              w_beat;
    wpbp_pkg::t_cell_ctl           w_ctl [DEPTH];
    logic [ENT_W-1:0]              w_new;
    logic [ENT_W-1:0]              w_cand;

    assign w_ent[DEPTH]  = '0;
    assign w_pres[DEPTH] = 1'b0;

    assign w_new  = {i_valid_req, i_barrier, i_prob};
    assign w_cand = w_ent[CTR];

    // Radius writes saturate at the build limit.
    assign w_radius_wr = (i_cfg_data[RW-1:0] > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                                : i_cfg_data[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= PROB_BITS'(wpbp_pkg::THRESH_RESET);
            r_radius <= wpbp_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wpbp_pkg::CFG_THRESHOLD: r_thresh <= i_cfg_data[PROB_BITS-1:0];
                wpbp_pkg::CFG_RADIUS:    r_radius <= w_radius_wr;
                default:                 r_thresh <= r_thresh;
            endcase
        end
    end

    // Decision scheduling: a pending frame is decided once radius newer
    // frames exist, or at once when the sequence has ended.
    assign w_radius_x  = CMPW'(r_radius);
    assign w_pend_m1   = r_pend - CW'(1);
    assign w_need      = r_busy && (r_pend != '0) &&
                         (r_last || (CMPW'(r_pend) > w_radius_x));
    assign w_more      = (w_pend_m1 != '0) &&
                         (r_last || (CMPW'(w_pend_m1) > w_radius_x));
    assign w_fire      = w_need && (!r_out_valid || !i_out_stall);
    assign w_item_done = r_busy && (!w_need || (w_fire && !w_more));
    assign w_ready     = !r_busy || w_item_done;
    assign w_in_acc    = i_in_valid && w_ready;
    assign w_pend_base = r_pend - CW'(w_fire);

    assign o_in_stall  = !w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_last <= 1'b0;
            r_pend <= '0;
        end else begin
            if (w_in_acc) begin
                r_busy <= 1'b1;
                r_last <= i_seq_last;
            end else if (w_item_done) begin
                r_busy <= 1'b0;
            end
            r_pend <= w_pend_base + CW'(w_in_acc);
        end
    end

    // Per-position cell control. Older frames beyond the left reach are
    // dropped only as the frame in hand finishes.
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        always_comb begin
            w_ctl[j].shift      = w_fire;
            w_ctl[j].clear      = w_item_done && r_last;
            w_ctl[j].load       = 1'b0;
            w_ctl[j].keep       = 1'b1;
            w_ctl[j].look_left  = 1'b0;
            w_ctl[j].look_right = 1'b0;
            if (j < CTR) begin
                w_ctl[j].look_left = (RW'(CTR - j) <= r_radius);
                w_ctl[j].keep      = !w_item_done || (RW'(CTR - j) <= r_radius);
            end else begin
                w_ctl[j].load = w_in_acc && (w_pend_base == CW'(j - CTR));
                if (j > CTR) begin
                    w_ctl[j].look_right = (RW'(j - CTR) <= r_radius);
                end
            end
        end

        wpbp_cell #(
            .PROB_BITS (PROB_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[j]),
            .i_new      (w_new),
            .i_nb_ent   (w_ent[j+1]),
            .i_nb_pres  (w_pres[j+1]),
            .i_cand_key (w_key[CTR]),
            .o_ent      (w_ent[j]),
            .o_pres     (w_pres[j]),
            .o_key      (w_key[j]),
            .o_beat     (w_beat[j])
        );
    end

    // The centre frame is a boundary when no neighbour beats it, it is a real
    // frame, and it is a barrier or reaches the threshold.
    assign w_decision = !(|w_beat) && w_cand[PROB_BITS+1] &&
                        (w_cand[PROB_BITS] || (w_cand[PROB_BITS-1:0] >= r_thresh));

    // Output register: loaded on each decision, freed when the transfer ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_boundary <= w_decision;
            r_run_end  <= !w_more;
            r_seq_end  <= !w_more && r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_boundary  = r_boundary;
    assign o_seq_end   = r_seq_end;
    assign o_run_end   = r_run_end;

`ifndef ASSERT_OFF
    // The row never holds more undecided frames than the right half plus one.
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= CW'(MAX_RADIUS + 1))
        else $error("pending count beyond window");

    // Whenever a frame is pending, the centre cell holds it.
    a_centre_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != '0) |-> w_pres[CTR])
        else $error("centre cell empty with frames pending");

    // The final frame of a sequence leaves nothing pending.
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_item_done && r_last && !w_in_acc) |=> (r_pend == '0))
        else $error("frames left after sequence end");

    // A frame within a sequence leaves at most radius frames pending.
    a_pend_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_item_done && !r_last && !w_in_acc) |=>
            (CMPW'(r_pend) <= CMPW'($past(r_radius))))
        else $error("more frames pending than the radius");

    // The last decision of a frame ends its work.
    a_run_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_more && !w_in_acc) |=> !r_busy)
        else $error("still busy after the final decision of a frame");
`endif

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Windowed peak boundary picker testbench
// Streams frames through the picker under random back-pressure and compares
// every boundary decision with a transaction-level model of the window.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PROB_W      = wpbp_pkg::PROB_BITS_DEF;
    localparam int REACH_MAX   = wpbp_pkg::MAX_RADIUS_DEF;
    localparam int REACH_W     = wpbp_pkg::RADIUS_W;
    localparam int WIN_DEPTH   = 2 * REACH_MAX + 1;
    localparam int DATA_W      = (PROB_W > REACH_W) ? PROB_W : REACH_W;
    localparam int SETTLE_CYC  = 4;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYC    = 200;
    localparam int HOLD_AFTER  = 60;

    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic              barrier;
        logic              valid_req;
        logic              seq_last;
    } t_frame;

    typedef struct packed {
        logic boundary;
        logic seq_end;
        logic run_end;
    } t_decision;

    // Block ports
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [wpbp_pkg::CFG_IDX_W-1:0] i_cfg_idx   = wpbp_pkg::CFG_THRESHOLD;
    logic [DATA_W-1:0]              i_cfg_data  = '0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    logic [PROB_W-1:0]              i_prob      = '0;
    logic                           i_barrier   = 1'b0;
    logic                           i_valid_req = 1'b0;
    logic                           i_seq_last  = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b1;
    logic                           o_boundary;
    logic                           o_seq_end;
    logic                           o_run_end;

    // Stimulus side
    t_frame            frames_to_send[$];
    t_frame            next_frame;
    logic              in_taken = 1'b0;
    int                send_idle_pct = 29;
    int                recv_idle_pct = 80;
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    logic [PROB_W-1:0] cur_thr = PROB_W'(wpbp_pkg::THRESH_RESET);
    logic [PROB_W-1:0] last_prob = '0;

    // Model of the window and the decisions it still owes
    logic [PROB_W+1:0] win_frames [WIN_DEPTH];
    int unsigned       left_cnt;
    int unsigned       pend_cnt;
    logic [PROB_W-1:0] thr_reg;
    logic [REACH_W-1:0] reach_reg;
    t_decision         decisions_due[$];
    t_decision         want;
    int                decisions_seen = 0;
    int                fault_count = 0;
    int                quiet_cycles = 0;

    windowed_peak_boundary_picker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_prob      (i_prob),
        .i_barrier   (i_barrier),
        .i_valid_req (i_valid_req),
        .i_seq_last  (i_seq_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_boundary  (o_boundary),
        .o_seq_end   (o_seq_end),
        .o_run_end   (o_run_end)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Padding and barrier frames rank above every probability.
    function automatic logic [PROB_W:0] frame_key(logic [PROB_W+1:0] f);
        if (!f[PROB_W+1] || f[PROB_W]) begin
            return {1'b1, {PROB_W{1'b0}}};
        end
        return {1'b0, f[PROB_W-1:0]};
    endfunction

    task automatic discard_oldest(int unsigned count);
        int unsigned total;
        int unsigned k;
        total = left_cnt + pend_cnt;
        if (count == 0 || count > total) begin
            return;
        end
        for (k = 0; k < total; k++) begin
            win_frames[k] = (k + count < total) ? win_frames[k + count] : '0;
        end
    endtask

    // Works out the decisions that one accepted frame releases.
    task automatic predict_decisions(t_frame f);
        int unsigned r, total, out_cnt, lo, hi, best, k, i;
        logic [PROB_W+1:0] centre;
        t_decision d;
        r = reach_reg;
        if (left_cnt + pend_cnt >= WIN_DEPTH) begin
            discard_oldest(1);
            if (left_cnt > 0) begin
                left_cnt--;
            end else begin
                pend_cnt--;
            end
        end
        total = left_cnt + pend_cnt;
        win_frames[total] = {f.valid_req, f.barrier, f.prob};
        pend_cnt++;
        total++;

        // The final frame flushes everything; otherwise only frames with a
        // full right reach are decided, under the radius in force now.
        if (f.seq_last) begin
            out_cnt = pend_cnt;
        end else if (pend_cnt > r) begin
            out_cnt = pend_cnt - r;
        end else begin
            out_cnt = 0;
        end
        if (out_cnt > REACH_MAX + 1) begin
            out_cnt = REACH_MAX + 1;
        end

        for (i = 0; i < out_cnt; i++) begin
            lo = (left_cnt >= r) ? left_cnt - r : 0;
            hi = left_cnt + r;
            if (hi > total - 1) begin
                hi = total - 1;
            end
            // Strictly greater keeps the leftmost maximum.
            best = lo;
            for (k = lo + 1; k <= hi; k++) begin
                if (frame_key(win_frames[k]) > frame_key(win_frames[best])) begin
                    best = k;
                end
            end
            centre = win_frames[left_cnt];
            d.boundary = (best == left_cnt) && centre[PROB_W+1] &&
                         (centre[PROB_W] || centre[PROB_W-1:0] >= thr_reg);
            d.seq_end  = f.seq_last && (i == out_cnt - 1);
            d.run_end  = (i == out_cnt - 1);
            decisions_due.push_back(d);
            left_cnt++;
            pend_cnt--;
        end

        // Forget the sequence at its end, else keep only the left reach.
        if (f.seq_last) begin
            for (k = 0; k < WIN_DEPTH; k++) begin
                win_frames[k] = '0;
            end
            left_cnt = 0;
            pend_cnt = 0;
        end else if (left_cnt > r) begin
            discard_oldest(left_cnt - r);
            left_cnt = r;
        end
    endtask

    task automatic push_frame(logic [PROB_W-1:0] p, logic b, logic v, logic l);
        frames_to_send.push_back({p, b, v, l});
    endtask

    // Random content, weighted towards the extremes, the threshold and ties.
    task automatic push_random_frame(logic l);
        int unsigned pick;
        logic [PROB_W-1:0] p;
        pick = $urandom_range(0, 15);
        case (pick)
            0:       p = '0;
            1:       p = '1;
            2, 3:    p = cur_thr + PROB_W'($urandom_range(0, 4)) - PROB_W'(2);
            4:       p = last_prob;
            default: p = PROB_W'($urandom);
        endcase
        last_prob = p;
        push_frame(p, $urandom_range(0, 9) == 0, $urandom_range(0, 9) != 0, l);
    endtask

    // Both registers are written back to back; spare data bits are random.
    task automatic program_regs(logic [PROB_W-1:0] thr, logic [REACH_W-1:0] reach);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= wpbp_pkg::CFG_THRESHOLD;
        i_cfg_data <= DATA_W'(thr);
        @(negedge i_clk);
        i_cfg_idx  <= wpbp_pkg::CFG_RADIUS;
        i_cfg_data <= (DATA_W'($urandom) << REACH_W) | DATA_W'(reach);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_thr = thr;
    endtask

    // Waits until every frame is in and every decision is out, then lets a
    // frame that released nothing finish.
    task automatic settle_idle();
        while (frames_to_send.size() != 0 || i_in_valid || decisions_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Sequences of random length with random content; the phase may stop in
    // the middle of one, and an open tail leaves frames pending on purpose.
    task automatic random_phase(int s_idle, int r_idle, logic [PROB_W-1:0] thr,
                                logic [REACH_W-1:0] reach, int frame_total, int open_tail);
        int unsigned seq_len, pos, max_len;
        int i;
        program_regs(thr, reach);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        max_len = 2 * reach + 8;
        pos = 0;
        seq_len = $urandom_range(1, max_len);
        for (i = 0; i < frame_total; i++) begin
            push_random_frame(pos == seq_len - 1);
            pos++;
            if (pos == seq_len) begin
                pos = 0;
                seq_len = $urandom_range(1, max_len);
            end
        end
        for (i = 0; i < open_tail; i++) begin
            push_random_frame(1'b0);
        end
        settle_idle();
    endtask

    // Frame driver: a new frame goes out only once the last one transferred.
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (frames_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_frame = frames_to_send.pop_front();
                i_in_valid  <= 1'b1;
                i_prob      <= next_frame.prob;
                i_barrier   <= next_frame.barrier;
                i_valid_req <= next_frame.valid_req;
                i_seq_last  <= next_frame.seq_last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Decision receiver: random stalls, and once a long hold-off so that the
    // block backs up into its input.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && decisions_seen >= HOLD_AFTER) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYC;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Monitor: register writes and input transfers feed the model, output
    // transfers are checked against the oldest decision owed.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            thr_reg   = PROB_W'(wpbp_pkg::THRESH_RESET);
            reach_reg = wpbp_pkg::RADIUS_RESET;
            left_cnt  = 0;
            pend_cnt  = 0;
            for (int k = 0; k < WIN_DEPTH; k++) begin
                win_frames[k] = '0;
            end
            decisions_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wpbp_pkg::CFG_THRESHOLD: thr_reg = i_cfg_data[PROB_W-1:0];
                    wpbp_pkg::CFG_RADIUS:    reach_reg = i_cfg_data[REACH_W-1:0];
                    default:                 thr_reg = thr_reg;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                predict_decisions({i_prob, i_barrier, i_valid_req, i_seq_last});
            end
            if (o_out_valid && !i_out_stall) begin
                decisions_seen++;
                if (decisions_due.size() == 0) begin
                    $error("decision with none owed: boundary %0b seq_end %0b run_end %0b",
                           o_boundary, o_seq_end, o_run_end);
                    fault_count++;
                end else begin
                    want = decisions_due.pop_front();
                    if (o_boundary !== want.boundary) begin
                        $error("boundary: expected %0b, actual %0b", want.boundary, o_boundary);
                        fault_count++;
                    end
                    if (o_seq_end !== want.seq_end) begin
                        $error("seq_end: expected %0b, actual %0b", want.seq_end, o_seq_end);
                        fault_count++;
                    end
                    if (o_run_end !== want.run_end) begin
                        $error("run_end: expected %0b, actual %0b", want.run_end, o_run_end);
                        fault_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer or register write.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: extremes, the threshold edge, a barrier, padding,
        // a tie, a one-frame sequence, and a sequence left open.
        push_frame(16'd0,     1'b0, 1'b1, 1'b0);
        push_frame(16'd65535, 1'b0, 1'b1, 1'b0);
        push_frame(16'd32768, 1'b0, 1'b1, 1'b0);
        push_frame(16'd32767, 1'b0, 1'b1, 1'b0);
        push_frame(16'd0,     1'b1, 1'b1, 1'b0);
        push_frame(16'd65535, 1'b0, 1'b0, 1'b0);
        push_frame(16'd40000, 1'b0, 1'b1, 1'b0);
        push_frame(16'd40000, 1'b0, 1'b1, 1'b0);
        push_frame(16'd40000, 1'b0, 1'b1, 1'b1);
        push_frame(16'd50000, 1'b0, 1'b1, 1'b1);
        push_frame(16'd32768, 1'b1, 1'b0, 1'b0);
        push_frame(16'd1000,  1'b0, 1'b1, 1'b0);
        push_frame(16'd60000, 1'b0, 1'b1, 1'b0);
        settle_idle();

        // Radius cut to zero in the middle of that sequence, top threshold,
        // and a final frame decided on its own.
        program_regs(16'hFFFF, 5'd0);
        push_frame(16'd65535, 1'b0, 1'b1, 1'b0);
        push_frame(16'd65534, 1'b0, 1'b1, 1'b0);
        push_frame(16'd0,     1'b1, 1'b1, 1'b1);
        push_frame(16'd65535, 1'b0, 1'b1, 1'b1);
        settle_idle();

        // Widest window, zero threshold, all keys equal.
        program_regs(16'h0000, 5'd31);
        push_frame(16'd0, 1'b0, 1'b1, 1'b0);
        push_frame(16'd0, 1'b0, 1'b1, 1'b0);
        push_frame(16'd0, 1'b0, 1'b1, 1'b1);
        settle_idle();

        // Random part. The widest-window phase ends with a long open tail so
        // that the next phase, at radius zero, flushes a full window at once.
        random_phase(29, 80, PROB_W'($urandom), REACH_W'($urandom_range(1, 6)), 52, 0);
        random_phase(29, 80, PROB_W'($urandom), 5'd31, 12, 40);
        random_phase(80, 29, 16'hFFFF, 5'd0, 52, 0);
        random_phase(80, 29, 16'h0000, REACH_W'($urandom_range(0, 31)), 52, 0);
        random_phase(0, 0, PROB_W'($urandom), 5'd1, 52, 0);
        random_phase(0, 0, PROB_W'($urandom), REACH_W'($urandom_range(2, 10)), 52, 0);

        if (fault_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
